>>> rtl/aligned_suballocator_core_defines.svh
// Assertion macros shared by the aligned suballocator RTL.
// Depends on nothing; included by the files that carry assertions.
`ifndef ALIGNED_SUBALLOCATOR_CORE_DEFINES_SVH
`define ALIGNED_SUBALLOCATOR_CORE_DEFINES_SVH
// Implication checked on every rising clock edge outside reset.
`define ASA_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication checked outside reset.
`define ASA_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

>>> rtl/asa_pkg.sv
// Package for the aligned suballocator: payload types, codes and states.
// Used by the interfaces, the divider and the top level.
package asa_pkg;
  localparam logic CMD_ALLOC   = 1'b0;
  localparam logic CMD_RELEASE = 1'b1;

  typedef struct packed {
    logic        cmd;
    logic [31:0] req_size;
    logic [12:0] align_base;
    logic [12:0] align_req;
    logic [5:0]  release_index;
  } in_item_t;

  typedef struct packed {
    logic        ok;
    logic [31:0] offset;
    logic [5:0]  block_index;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_GCD_START, ST_GCD_WAIT, ST_LCM, ST_WALK_RD, ST_WALK_CHK,
    ST_WALK_DIV, ST_WALK_FIT, ST_FIN_DIV, ST_FIN_CHK, ST_DONE
  } state_t;

  typedef struct packed {
    logic        start;
    logic [32:0] dividend;
    logic [12:0] divisor;
  } div_req_t;
endpackage

>>> rtl/asa_in_if.sv
// Request channel interface of the aligned suballocator.
// Depends on asa_pkg.
interface asa_in_if;
  logic              valid;
  logic              ready;
  asa_pkg::in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> rtl/asa_out_if.sv
// Result channel interface of the aligned suballocator.
// Depends on asa_pkg.
interface asa_out_if;
  logic               valid;
  logic               ready;
  asa_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> rtl/asa_div.sv
// Restoring divider, one quotient bit per cycle, 33-bit dividend by 13-bit divisor.
// Depends on asa_pkg; gives quotient and remainder.
module asa_div (
  input  logic              clk,
  input  logic              rst_n,
  input  asa_pkg::div_req_t req,
  output logic              busy,
  output logic              done,
  output logic [32:0]       quot,
  output logic [12:0]       rem
);
  logic [5:0]  cnt_r, cnt_nxt;
  logic [32:0] q_r, q_nxt;
  logic [13:0] rm_r, rm_nxt;
  logic [12:0] d_r, d_nxt;
  logic        done_r, done_nxt;
  logic [13:0] sh;

  always_comb begin
    cnt_nxt  = cnt_r;
    q_nxt    = q_r;
    rm_nxt   = rm_r;
    d_nxt    = d_r;
    done_nxt = 1'b0;
    sh       = {rm_r[12:0], q_r[32]};
    if (req.start) begin
      cnt_nxt = 6'd33;
      q_nxt   = req.dividend;
      rm_nxt  = '0;
      d_nxt   = req.divisor;
    end else if (cnt_r != 6'd0) begin
      cnt_nxt = cnt_r - 6'd1;
      if (sh >= {1'b0, d_r}) begin
        rm_nxt = sh - {1'b0, d_r};
        q_nxt  = {q_r[31:0], 1'b1};
      end else begin
        rm_nxt = sh;
        q_nxt  = {q_r[31:0], 1'b0};
      end
      done_nxt = (cnt_r == 6'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
    q_r  <= q_nxt;
    rm_r <= rm_nxt;
    d_r  <= d_nxt;
  end

  assign busy = (cnt_r != 6'd0);
  assign done = done_r;
  assign quot = q_r;
  assign rem  = rm_r[12:0];
endmodule

>>> rtl/aligned_suballocator_core.sv
// Aligned suballocator: one request at a time. GCD, LCM and round-ups with a unit that fits
// 13 bits run on one shared divider; wider units use a shift-subtract loop. A release result
// goes through ST_DONE into the output valid register. An allocate runs the alignment
// GCD steps and the LCM, then a round-up per free entry tried and one for the append.
// A new request is accepted only once the previous result has been taken.
// Reset (synchronous, rst_n low) empties the table and restores pool_size to 104857600.
module aligned_suballocator_core #(
  parameter int MAX_BLOCKS = 64
) (
  input  logic         clk,
  input  logic         rst_n,
  asa_in_if.sink       in_ch,
  asa_out_if.source    out_ch,
  input  logic         cfg_we,
  input  logic [31:0]  cfg_wdata
);
`include "aligned_suballocator_core_defines.svh"

  localparam int IW = $clog2(MAX_BLOCKS);
  localparam int CW = $clog2(MAX_BLOCKS + 1);
  localparam int RW = (CW > 6) ? CW : 6;

  // Block table: offset and size together in one synchronous memory.
  logic [63:0] tbl_mem [MAX_BLOCKS];
  logic [63:0] tbl_rd_r;
  logic [MAX_BLOCKS-1:0] free_r, free_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [31:0] pool_r;

  asa_pkg::state_t state_r, state_nxt;
  asa_pkg::in_item_t req_r, req_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic [12:0] ga_r, ga_nxt, gb_r, gb_nxt;   // gcd operands
  logic [12:0] a_r, a_nxt;
  logic [24:0] unit_r, unit_nxt;
  logic [32:0] far_r, far_nxt;
  logic [32:0] alg_r, alg_nxt;
  asa_pkg::out_item_t res_r, res_nxt;
  logic out_valid_r, out_valid_nxt;

  logic wr_en;
  logic [IW-1:0] wr_addr, rd_addr;
  logic [63:0] wr_data;

  asa_pkg::div_req_t dreq;
  logic d_busy, d_done;
  logic [32:0] d_quot;
  logic [12:0] d_rem;

  // Unit may reach 4096*4095 > 13 bits; the round-up divider takes unit as a
  // 13-bit divisor, so round-up is done by the remainder against unit only
  // when unit fits 13 bits; otherwise a second path below handles it.
  logic unit_small;
  assign unit_small = (unit_r[24:13] == '0);

  asa_div u_div (
    .clk(clk), .rst_n(rst_n), .req(dreq),
    .busy(d_busy), .done(d_done), .quot(d_quot), .rem(d_rem)
  );

  // Wide round-up by repeated subtraction is too slow, so large units use a
  // quotient-digit loop: remainder of x mod unit via shift-subtract.
  logic [5:0]  wc_r, wc_nxt;
  logic [32:0] wx_r, wx_nxt;
  logic [25:0] wrm_r, wrm_nxt;
  logic        wbusy;
  assign wbusy = (wc_r != 6'd0);

  // The remainder is final when the divider pulses done, or when the wide
  // loop has run down to zero.
  logic rnd_done;
  assign rnd_done = unit_small ? d_done : !wbusy;

  logic [31:0] ent_off, ent_sz;
  logic [33:0] fit;
  logic [32:0] fifth3;
  logic [33:0] fin_sum;
  logic [24:0] rmd;
  logic        fit_ok;

  // Block size divided by five through a reciprocal multiply, registered; the
  // table word stays put for the whole round-up, so the value is ready in time.
  logic [63:0] sz_recip;
  logic [29:0] fifth_r;

  assign ent_off  = tbl_rd_r[63:32];
  assign ent_sz   = tbl_rd_r[31:0];
  assign rmd      = unit_small ? {12'd0, d_rem} : wrm_r[24:0];
  assign fit      = {1'b0, alg_r} + {2'b0, req_r.req_size} - {2'b0, ent_off};
  assign sz_recip = {32'd0, ent_sz} * 64'h0000_0000_CCCC_CCCD;
  assign fifth3   = {3'd0, fifth_r} + {2'd0, fifth_r, 1'b0};
  assign fin_sum  = {1'b0, alg_r} + {2'b0, req_r.req_size};
  assign fit_ok   = (fit <= {2'b0, ent_sz}) && (fit >= {1'b0, fifth3});

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      asa_pkg::ST_IDLE: if (in_ch.valid && in_ch.ready) begin
        state_nxt = (in_ch.data.cmd == asa_pkg::CMD_RELEASE) ? asa_pkg::ST_DONE
                                                             : asa_pkg::ST_GCD_START;
      end
      asa_pkg::ST_GCD_START: state_nxt = (gb_r == '0) ? asa_pkg::ST_LCM
                                                      : asa_pkg::ST_GCD_WAIT;
      asa_pkg::ST_GCD_WAIT: if (d_done) state_nxt = asa_pkg::ST_GCD_START;
      asa_pkg::ST_LCM: if (d_done) state_nxt = asa_pkg::ST_WALK_RD;
      asa_pkg::ST_WALK_RD: state_nxt = (idx_r < count_r) ? asa_pkg::ST_WALK_CHK
                                                         : asa_pkg::ST_FIN_DIV;
      asa_pkg::ST_WALK_CHK: state_nxt = free_r[idx_r[IW-1:0]] ? asa_pkg::ST_WALK_DIV
                                                              : asa_pkg::ST_WALK_RD;
      asa_pkg::ST_WALK_DIV: if (rnd_done) state_nxt = asa_pkg::ST_WALK_FIT;
      asa_pkg::ST_WALK_FIT: begin
        if (fit_ok) state_nxt = asa_pkg::ST_DONE;
        else state_nxt = asa_pkg::ST_WALK_RD;
      end
      asa_pkg::ST_FIN_DIV: if (rnd_done) state_nxt = asa_pkg::ST_FIN_CHK;
      asa_pkg::ST_FIN_CHK: state_nxt = asa_pkg::ST_DONE;
      asa_pkg::ST_DONE: if (!out_valid_r || out_ch.ready) state_nxt = asa_pkg::ST_IDLE;
      default: state_nxt = asa_pkg::ST_IDLE;
    endcase
  end

  // Divider and table-port control plus datapath updates.
  logic div_kick;
  logic [32:0] div_x;
  always_comb begin
    req_nxt = req_r; idx_nxt = idx_r; ga_nxt = ga_r; gb_nxt = gb_r; a_nxt = a_r;
    unit_nxt = unit_r; far_nxt = far_r; alg_nxt = alg_r; res_nxt = res_r;
    free_nxt = free_r; count_nxt = count_r; out_valid_nxt = out_valid_r;
    wr_en = 1'b0; wr_addr = count_r[IW-1:0]; wr_data = '0;
    rd_addr = idx_r[IW-1:0];
    dreq = '0; div_kick = 1'b0; div_x = '0;
    wc_nxt = wc_r; wx_nxt = wx_r; wrm_nxt = wrm_r;
    if (out_ch.valid && out_ch.ready) out_valid_nxt = 1'b0;

    if (wbusy) begin
      wc_nxt = wc_r - 6'd1;
      wx_nxt = {wx_r[31:0], 1'b0};
      if ({wrm_r[24:0], wx_r[32]} >= {1'b0, unit_r}) begin
        wrm_nxt = {wrm_r[24:0], wx_r[32]} - {1'b0, unit_r};
      end else begin
        wrm_nxt = {wrm_r[24:0], wx_r[32]};
      end
    end

    unique case (state_r)
      asa_pkg::ST_IDLE: if (in_ch.valid && in_ch.ready) begin
        req_nxt = in_ch.data;
        res_nxt = '0;
        if (in_ch.data.cmd == asa_pkg::CMD_RELEASE) begin
          if (RW'(in_ch.data.release_index) < RW'(count_r)) begin
            free_nxt[IW'(in_ch.data.release_index)] = 1'b1;
            res_nxt.ok = 1'b1;
            res_nxt.block_index = in_ch.data.release_index;
          end
        end else begin
          ga_nxt = (in_ch.data.align_base != '0) ? in_ch.data.align_base
                 : (in_ch.data.align_req != '0) ? in_ch.data.align_req : 13'd1;
          gb_nxt = (in_ch.data.align_req != '0) ? in_ch.data.align_req : ga_nxt;
          a_nxt = ga_nxt;
        end
        idx_nxt = '0;
        far_nxt = '0;
      end
      asa_pkg::ST_GCD_START: begin
        // One Euclid step while the second operand is non-zero; once it is
        // zero, ga_r holds the GCD and the division a / gcd starts.
        dreq.start = 1'b1;
        if (gb_r != '0) begin
          dreq.dividend = {20'd0, ga_r}; dreq.divisor = gb_r;
        end else begin
          dreq.dividend = {20'd0, a_r}; dreq.divisor = ga_r;
        end
      end
      asa_pkg::ST_GCD_WAIT: if (d_done) begin
        ga_nxt = gb_r; gb_nxt = d_rem;
      end
      asa_pkg::ST_LCM: if (d_done) begin
        // unit = (a / gcd) * b, b being the other alignment.
        unit_nxt = {12'd0, d_quot[12:0]} *
                   ((req_r.align_req != '0) ? {12'd0, req_r.align_req} : {12'd0, a_r});
      end
      asa_pkg::ST_WALK_RD: begin
        if (idx_r >= count_r) begin
          div_kick = 1'b1; div_x = far_r;
          alg_nxt = far_r;
        end
      end
      asa_pkg::ST_WALK_CHK: begin
        if ({1'b0, far_r} <= {2'b0, ent_off}) far_nxt = {1'b0, ent_off} + {1'b0, ent_sz};
        if (free_r[idx_r[IW-1:0]]) begin
          div_kick = 1'b1; div_x = {1'b0, ent_off}; alg_nxt = {1'b0, ent_off};
        end else idx_nxt = idx_r + 1'b1;
      end
      asa_pkg::ST_WALK_FIT: begin
        if (fit_ok) begin
          free_nxt[idx_r[IW-1:0]] = 1'b0;
          res_nxt.ok = 1'b1; res_nxt.offset = alg_r[31:0];
          res_nxt.block_index = 6'(idx_r);
        end else idx_nxt = idx_r + 1'b1;
      end
      asa_pkg::ST_FIN_CHK: begin
        if (fin_sum <= {2'b0, pool_r} && count_r < CW'(MAX_BLOCKS)) begin
          wr_en = 1'b1;
          wr_data = {alg_r[31:0], 32'(fin_sum - {1'b0, far_r})};
          free_nxt[count_r[IW-1:0]] = 1'b0;
          res_nxt.ok = 1'b1; res_nxt.offset = alg_r[31:0];
          res_nxt.block_index = 6'(count_r);
          count_nxt = count_r + 1'b1;
        end
      end
      asa_pkg::ST_DONE: if (!out_valid_r || out_ch.ready) out_valid_nxt = 1'b1;
      default: ;
    endcase

    if (div_kick) begin
      if (unit_small) begin
        dreq.start = 1'b1; dreq.dividend = div_x; dreq.divisor = unit_r[12:0];
      end else begin
        wc_nxt = 6'd33; wx_nxt = div_x; wrm_nxt = '0;
      end
    end
  end

  // Round-up applied on entry into the fit and final check states.
  logic [32:0] alg_up;
  assign alg_up = (rmd != '0) ? alg_r + 33'(unit_r - rmd) : alg_r;
  logic entering_chk;
  assign entering_chk = (state_r == asa_pkg::ST_WALK_DIV || state_r == asa_pkg::ST_FIN_DIV) &&
                        rnd_done;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= asa_pkg::ST_IDLE; free_r <= '0; count_r <= '0;
      pool_r <= 32'd104857600; out_valid_r <= 1'b0; wc_r <= '0;
    end else begin
      state_r <= state_nxt; free_r <= free_nxt; count_r <= count_nxt;
      out_valid_r <= out_valid_nxt; wc_r <= wc_nxt;
      if (cfg_we) pool_r <= cfg_wdata;
    end
    req_r <= req_nxt; idx_r <= idx_nxt; ga_r <= ga_nxt; gb_r <= gb_nxt; a_r <= a_nxt;
    unit_r <= unit_nxt; far_r <= far_nxt; res_r <= res_nxt;
    wx_r <= wx_nxt; wrm_r <= wrm_nxt;
    fifth_r <= sz_recip[63:34];
    alg_r <= entering_chk ? alg_up : alg_nxt;
  end

  // Table memory, one write and one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) tbl_mem[wr_addr] <= wr_data;
    tbl_rd_r <= tbl_mem[rd_addr];
  end

  // The request side opens only once the previous result has been taken.
  assign in_ch.ready  = (state_r == asa_pkg::ST_IDLE) && !out_valid_r;
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = res_r;

  `ASA_ASSERT_IMP(a_count_bound, clk, rst_n, 1'b1, count_r <= CW'(MAX_BLOCKS),
    "block count beyond table depth")
  `ASA_ASSERT_IMP(a_ready_idle, clk, rst_n, in_ch.ready, !d_busy && !wbusy,
    "accepting while a division runs")
  `ASA_ASSERT_NXT(a_count_step, clk, rst_n, wr_en, count_r == $past(count_r) + 1'b1,
    "append did not advance count")
endmodule
